// ===== design/ifcs_pkg.sv =====
// shared types and byte codes for the irc format code stripper
// no dependencies
package ifcs_pkg;

    localparam logic [7:0] BYTE_CTCP  = 8'h01;
    localparam logic [7:0] BYTE_BOLD  = 8'h02;
    localparam logic [7:0] BYTE_COLOR = 8'h03;
    localparam logic [7:0] BYTE_BELL  = 8'h07;
    localparam logic [7:0] BYTE_ESC   = 8'h1b;
    localparam logic [7:0] BYTE_REV   = 8'h16;
    localparam logic [7:0] BYTE_UNDER = 8'h1f;
    localparam logic [7:0] BYTE_COMMA = 8'h2c;
    localparam logic [7:0] BYTE_SEMI  = 8'h3b;
    localparam logic [7:0] BYTE_BRACK = 8'h5b;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    // one queued word: up to two result bytes caused by one input byte
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       valid0;
        logic       two;
        logic       last;
    } word_t;

endpackage

// ===== design/ifcs_front.sv =====
// front part: parse state machine, classifies each input byte into a queue word
// depends on ifcs_pkg
module ifcs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         in_byte,
    input  logic               end_of_line,
    input  logic               q_full,
    output logic               q_push,
    output ifcs_pkg::word_t    q_word
);

    localparam logic [2:0] MODE_TEXT  = 3'd0;
    localparam logic [2:0] MODE_CTLC  = 3'd1;
    localparam logic [2:0] MODE_FG1   = 3'd2;
    localparam logic [2:0] MODE_FG2   = 3'd3;
    localparam logic [2:0] MODE_COMMA = 3'd4;
    localparam logic [2:0] MODE_BG1   = 3'd5;
    localparam logic [2:0] MODE_ESC   = 3'd6;
    localparam logic [2:0] MODE_CSI   = 3'd7;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [2:0] parse_next;
    logic [2:0] plain_mode;
    logic       plain_keep;
    logic       is_digit;
    logic       use_plain;
    logic       hold_put;
    logic [7:0] hold_byte;
    logic       keep;
    logic       eol_put;
    logic [7:0] eol_byte;
    logic       any;
    logic       accept;

    assign is_digit = (in_byte >= ifcs_pkg::BYTE_ZERO) && (in_byte <= ifcs_pkg::BYTE_NINE);

    // handling of a byte in normal text
    always_comb
    begin
        plain_mode = MODE_TEXT;
        plain_keep = 1'b0;
        unique case (in_byte) inside
            ifcs_pkg::BYTE_CTCP, ifcs_pkg::BYTE_BOLD, ifcs_pkg::BYTE_BELL,
            ifcs_pkg::BYTE_REV, ifcs_pkg::BYTE_UNDER:
            begin
                plain_mode = MODE_TEXT;
            end
            ifcs_pkg::BYTE_COLOR:
            begin
                plain_mode = MODE_CTLC;
            end
            ifcs_pkg::BYTE_ESC:
            begin
                plain_mode = MODE_ESC;
            end
            default:
            begin
                plain_keep = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        parse_next = mode_reg;
        use_plain  = 1'b0;
        hold_put   = 1'b0;
        hold_byte  = ifcs_pkg::BYTE_COLOR;
        unique case (mode_reg)
            MODE_CTLC:
            begin
                if (is_digit)
                begin
                    parse_next = MODE_FG1;
                end
                else
                begin
                    hold_put  = 1'b1;
                    use_plain = 1'b1;
                end
            end
            MODE_FG1:
            begin
                if (is_digit)
                begin
                    parse_next = MODE_FG2;
                end
                else if (in_byte == ifcs_pkg::BYTE_COMMA)
                begin
                    parse_next = MODE_COMMA;
                end
                else
                begin
                    use_plain = 1'b1;
                end
            end
            MODE_FG2:
            begin
                if (in_byte == ifcs_pkg::BYTE_COMMA)
                begin
                    parse_next = MODE_COMMA;
                end
                else
                begin
                    use_plain = 1'b1;
                end
            end
            MODE_COMMA:
            begin
                if (is_digit)
                begin
                    parse_next = MODE_BG1;
                end
                else
                begin
                    hold_put  = 1'b1;
                    hold_byte = ifcs_pkg::BYTE_COMMA;
                    use_plain = 1'b1;
                end
            end
            MODE_BG1:
            begin
                if (is_digit)
                begin
                    parse_next = MODE_TEXT;
                end
                else
                begin
                    use_plain = 1'b1;
                end
            end
            MODE_ESC:
            begin
                if (in_byte == ifcs_pkg::BYTE_BRACK)
                begin
                    parse_next = MODE_CSI;
                end
                else
                begin
                    use_plain = 1'b1;
                end
            end
            MODE_CSI:
            begin
                if (!(is_digit || in_byte == ifcs_pkg::BYTE_SEMI))
                begin
                    parse_next = MODE_TEXT;
                end
            end
            default:
            begin
                use_plain = 1'b1;
            end
        endcase
        if (use_plain)
        begin
            parse_next = plain_mode;
        end
    end

    assign keep     = use_plain && plain_keep;
    assign eol_put  = end_of_line && (parse_next == MODE_CTLC || parse_next == MODE_COMMA);
    assign eol_byte = (parse_next == MODE_CTLC) ? ifcs_pkg::BYTE_COLOR : ifcs_pkg::BYTE_COMMA;
    assign any      = hold_put || keep || eol_put;

    // pack results in order: held byte, kept byte, byte released at end of line
    always_comb
    begin
        q_word.byte0  = 8'h00;
        q_word.byte1  = eol_byte;
        q_word.valid0 = any;
        q_word.two    = (hold_put && keep) || ((hold_put || keep) && eol_put);
        q_word.last   = end_of_line;
        if (hold_put)
        begin
            q_word.byte0 = hold_byte;
        end
        else if (keep)
        begin
            q_word.byte0 = in_byte;
        end
        else if (eol_put)
        begin
            q_word.byte0 = eol_byte;
        end
        if (hold_put && keep)
        begin
            q_word.byte1 = in_byte;
        end
    end

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign q_push    = accept && (any || end_of_line);
    assign mode_next = end_of_line ? MODE_TEXT : parse_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== design/ifcs_queue.sv =====
// short word queue between front and back parts, flip-flop storage
// depends on ifcs_pkg
module ifcs_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ifcs_pkg::word_t    wr_word,
    output logic               q_full,
    input  logic               rd_en,
    output ifcs_pkg::word_t    rd_word,
    output logic               q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    ifcs_pkg::word_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_MAX);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_word = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// ===== design/ifcs_back.sv =====
// back part: splits each queued word into one or two result bytes
// depends on ifcs_pkg
module ifcs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  ifcs_pkg::word_t    head_word,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_byte,
    output logic               out_valid,
    output logic               out_last
);

    logic phase_reg;
    logic phase_next;
    logic take;

    assign empty     = q_empty;
    assign take      = pop && !q_empty;
    assign q_pop     = take && (!head_word.two || phase_reg);
    assign out_byte  = phase_reg ? head_word.byte1 : head_word.byte0;
    assign out_valid = phase_reg ? 1'b1 : head_word.valid0;
    // second byte of a double word carries the last mark
    assign out_last  = head_word.last && (phase_reg || !head_word.two);

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = head_word.two && !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== design/irc_format_code_stripper.sv =====
// top level of the irc format code stripper
// depends on ifcs_pkg, ifcs_front, ifcs_queue, ifcs_back
//
// One input byte can be taken in every clock cycle while full is low. The front parser turns
// each byte into at most one queue word holding zero to two result bytes, and the back part
// hands out one result byte per cycle while pop is high and the queue is not empty. The
// QueueDepth-word queue between them sets the stall behavior: full rises when it holds
// QueueDepth words, and a word with two results stays at the head until both are out. A line
// end always gives a result with out_last set; it has out_valid low when no byte is left.
module irc_format_code_stripper
#(
    parameter int QueueDepth = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_line,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last
);

    ifcs_pkg::word_t wr_word;
    ifcs_pkg::word_t head_word;
    logic            q_full;
    logic            q_push;
    logic            q_empty;
    logic            q_pop;

    ifcs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .end_of_line (end_of_line),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (wr_word)
    );

    ifcs_queue #(.DEPTH(QueueDepth)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (wr_word),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_word (head_word),
        .q_empty (q_empty)
    );

    ifcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_word (head_word),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

endmodule
